// File: sv/brbo_pkg.sv
// Shared types and constants for the byte ring buffer with overwrite and peek.
// Used by the front end, the command queue, the back end and the top level.
package brbo_pkg;

  localparam int unsigned LOG2_CAPACITY = 10;
  localparam int unsigned MAX_BURST     = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned ADDR_W  = LOG2_CAPACITY;
  localparam int unsigned CAP_W   = LOG2_CAPACITY + 1;
  localparam int unsigned LG_W    = 4;
  localparam int unsigned BURST_W = $clog2(MAX_BURST + 1);
  localparam int unsigned QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FILL_W  = 11;
  localparam int unsigned MAX_FILL = 1 << LOG2_CAPACITY;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_TRY_WRITE  = 3'd1,
    OP_READ       = 3'd2,
    OP_PEEK       = 3'd3,
    OP_CONSUME_IF = 3'd4,
    OP_CONSUME    = 3'd5,
    OP_RESET      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_DISCARDED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SIZE_LOG2 = 2'd0,
    CFG_OVERWRITE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                burst;
    status_e             status;
    logic [15:0]         count;
    logic [31:0]         rd_cnt;
    logic [31:0]         wr_cnt;
    logic [CAP_W-1:0]    cap;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   mask;
    logic [BURST_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              in_ready;
    logic [QCNT_W-1:0] pend_cnt;
  } front_stat_t;

  typedef struct packed {
    logic pop;
    logic burst_done;
  } back_ctl_t;

endpackage

// File: sv/brbo_front.sv
// Front end: configuration registers, ring counters and chunk state.
// Decides each word and pushes one command into the queue; uses brbo_pkg.
module brbo_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [3:0]                cfg_data_i,
  input  logic                      in_valid_i,
  input  logic [2:0]                opcode_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      first_of_chunk_i,
  input  logic [15:0]               chunk_length_i,
  input  logic [15:0]               request_count_i,
  input  logic [31:0]               snapshot_value_i,
  input  logic                      q_full_i,
  input  brbo_pkg::back_ctl_t       back_i,
  output brbo_pkg::front_stat_t     stat_o,
  output logic                      push_o,
  output brbo_pkg::cmd_t            cmd_o,
  output brbo_pkg::mem_wr_t         wr_o
);

  logic [brbo_pkg::LG_W-1:0]   size_log2_q;
  logic                        overwrite_q;
  logic [31:0]                 wr_cnt_q, wr_cnt_d;
  logic [31:0]                 rd_cnt_q, rd_cnt_d;
  logic [15:0]                 remain_q, remain_d;
  logic                        accepted_q, accepted_d;
  logic [brbo_pkg::QCNT_W-1:0] pend_q, pend_d;

  brbo_pkg::op_e               op;
  logic [brbo_pkg::LG_W-1:0]   lg;
  logic [brbo_pkg::CAP_W-1:0]  cap;
  logic [brbo_pkg::ADDR_W-1:0] mask;
  logic [31:0]                 avail;
  logic [32:0]                 need;
  logic [31:0]                 take;
  logic [brbo_pkg::BURST_W-1:0] burst_len;
  logic [15:0]                 consume_len;
  logic                        is_write;
  logic                        accept;
  logic                        ok;

  assign op       = brbo_pkg::op_e'(opcode_i);
  assign is_write = (op == brbo_pkg::OP_WRITE) || (op == brbo_pkg::OP_TRY_WRITE);

  always_comb begin
    lg = size_log2_q;
    if (lg < brbo_pkg::LG_W'(1)) begin
      lg = brbo_pkg::LG_W'(1);
    end else if (32'(lg) > 32'(brbo_pkg::LOG2_CAPACITY)) begin
      lg = brbo_pkg::LG_W'(brbo_pkg::LOG2_CAPACITY);
    end
  end

  assign cap   = brbo_pkg::CAP_W'(1) << lg;
  assign mask  = brbo_pkg::ADDR_W'(cap - brbo_pkg::CAP_W'(1));
  assign avail = wr_cnt_q - rd_cnt_q;
  assign need  = {1'b0, avail} + 33'(chunk_length_i);
  assign take  = (avail < 32'(request_count_i)) ? avail : 32'(request_count_i);
  assign burst_len = (take > 32'(brbo_pkg::MAX_BURST)) ?
                     brbo_pkg::BURST_W'(brbo_pkg::MAX_BURST) : brbo_pkg::BURST_W'(take);
  assign consume_len = take[15:0];

  assign stat_o.in_ready = !q_full_i && !(is_write && (pend_q != '0));
  assign stat_o.pend_cnt = pend_q;
  assign accept          = in_valid_i && stat_o.in_ready;
  assign push_o          = accept;

  always_comb begin
    wr_cnt_d    = wr_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    remain_d    = remain_q;
    accepted_d  = accepted_q;
    ok          = 1'b1;
    wr_o.en     = 1'b0;
    wr_o.addr   = wr_cnt_q[brbo_pkg::ADDR_W-1:0] & mask;
    wr_o.data   = data_byte_i;
    cmd_o.burst  = 1'b0;
    cmd_o.status = brbo_pkg::ST_OK;
    cmd_o.count  = '0;
    cmd_o.cap    = cap;
    cmd_o.base   = rd_cnt_q[brbo_pkg::ADDR_W-1:0] & mask;
    cmd_o.mask   = mask;
    cmd_o.len    = burst_len;
    case (op)
      brbo_pkg::OP_WRITE, brbo_pkg::OP_TRY_WRITE: begin
        if (first_of_chunk_i) begin
          if ((chunk_length_i == '0) || (chunk_length_i > 16'(cap))) begin
            ok = 1'b0;
          end else if (need > 33'(cap)) begin
            if ((op == brbo_pkg::OP_TRY_WRITE) || !overwrite_q) begin
              ok = 1'b0;
            end else begin
              rd_cnt_d = wr_cnt_q + 32'(chunk_length_i) - 32'(cap);
            end
          end
          remain_d   = (chunk_length_i != '0) ? chunk_length_i - 16'd1 : '0;
          accepted_d = ok;
          if (ok) begin
            wr_o.en     = 1'b1;
            wr_cnt_d    = wr_cnt_q + 32'd1;
            cmd_o.count = 16'd1;
          end else begin
            cmd_o.status = brbo_pkg::ST_REJECTED;
          end
        end else if ((remain_q != '0) && accepted_q) begin
          remain_d    = remain_q - 16'd1;
          wr_o.en     = 1'b1;
          wr_cnt_d    = wr_cnt_q + 32'd1;
          cmd_o.count = 16'd1;
        end else begin
          if (remain_q != '0) begin
            remain_d = remain_q - 16'd1;
          end
          cmd_o.status = brbo_pkg::ST_DISCARDED;
        end
      end
      brbo_pkg::OP_READ, brbo_pkg::OP_PEEK: begin
        if (burst_len != '0) begin
          cmd_o.burst = 1'b1;
          cmd_o.count = 16'(burst_len);
          if (op == brbo_pkg::OP_READ) begin
            rd_cnt_d = rd_cnt_q + 32'(burst_len);
          end
        end
      end
      brbo_pkg::OP_CONSUME_IF: begin
        if ((request_count_i != '0) && (rd_cnt_q == snapshot_value_i) &&
            (32'(request_count_i) <= avail)) begin
          rd_cnt_d    = rd_cnt_q + 32'(request_count_i);
          cmd_o.count = request_count_i;
        end else begin
          cmd_o.status = brbo_pkg::ST_REJECTED;
        end
      end
      brbo_pkg::OP_CONSUME: begin
        rd_cnt_d    = rd_cnt_q + 32'(consume_len);
        cmd_o.count = consume_len;
      end
      brbo_pkg::OP_RESET: begin
        wr_cnt_d   = '0;
        rd_cnt_d   = '0;
        remain_d   = '0;
        accepted_d = 1'b0;
      end
      default: begin
        cmd_o.status = brbo_pkg::ST_REJECTED;
      end
    endcase
    wr_o.en      = wr_o.en && accept;
    cmd_o.rd_cnt = rd_cnt_d;
    cmd_o.wr_cnt = wr_cnt_d;
  end

  always_comb begin
    pend_d = pend_q;
    if (accept && cmd_o.burst) begin
      pend_d = pend_d + brbo_pkg::QCNT_W'(1);
    end
    if (back_i.burst_done) begin
      pend_d = pend_d - brbo_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= brbo_pkg::LG_W'(brbo_pkg::LOG2_CAPACITY);
      overwrite_q <= 1'b0;
      wr_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      remain_q    <= '0;
      accepted_q  <= 1'b0;
      pend_q      <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == brbo_pkg::CFG_SIZE_LOG2)) begin
        size_log2_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == brbo_pkg::CFG_OVERWRITE)) begin
        overwrite_q <= cfg_data_i[0];
      end
      if (accept) begin
        wr_cnt_q   <= wr_cnt_d;
        rd_cnt_q   <= rd_cnt_d;
        remain_q   <= remain_d;
        accepted_q <= accepted_d;
      end
      pend_q <= pend_d;
    end
  end

endmodule

// File: sv/brbo_cmd_q.sv
// Short command queue between the front end and the back end.
// Holds brbo_pkg::cmd_t entries and shows the oldest one at its head.
module brbo_cmd_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brbo_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output brbo_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  brbo_pkg::cmd_t              entry_q [brbo_pkg::QUEUE_DEPTH];
  logic [brbo_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [brbo_pkg::QCNT_W-1:0] cnt_q;

  assign head_o  = entry_q[rd_ptr_q];
  assign full_o  = (32'(cnt_q) == 32'(brbo_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

  function automatic logic [brbo_pkg::QPTR_W-1:0] next_ptr(
    input logic [brbo_pkg::QPTR_W-1:0] ptr
  );
    if (32'(ptr) == 32'(brbo_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + brbo_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + brbo_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - brbo_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: sv/brbo_back.sv
// Back end: byte store and output register; expands queued commands into words.
// Takes commands from brbo_cmd_q and write requests from brbo_front; uses brbo_pkg.
module brbo_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brbo_pkg::mem_wr_t           wr_i,
  input  brbo_pkg::cmd_t              head_i,
  input  logic                        q_empty_i,
  output brbo_pkg::back_ctl_t         ctl_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [7:0]                  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        last_o,
  output brbo_pkg::status_e           status_o,
  output logic [15:0]                 count_o,
  output logic [31:0]                 read_counter_o,
  output logic [brbo_pkg::FILL_W-1:0] fill_level_o
);

  logic [7:0]                   store_q [1 << brbo_pkg::ADDR_W];
  logic                         out_valid_q;
  logic [brbo_pkg::BURST_W-1:0] idx_q;
  logic                         slot_free;
  logic                         load;
  logic                         is_last;
  logic [brbo_pkg::ADDR_W-1:0]  rd_addr;
  logic [31:0]                  used;
  logic [brbo_pkg::CAP_W-1:0]   fill;

  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = !q_empty_i && slot_free;
  assign is_last   = !head_i.burst || (idx_q == head_i.len - brbo_pkg::BURST_W'(1));
  assign rd_addr   = (head_i.base + brbo_pkg::ADDR_W'(idx_q)) & head_i.mask;
  assign used      = head_i.wr_cnt - head_i.rd_cnt;
  assign fill      = (used > 32'(head_i.cap)) ? head_i.cap : brbo_pkg::CAP_W'(used);

  assign ctl_o.pop        = load && is_last;
  assign ctl_o.burst_done = load && is_last && head_i.burst;
  assign out_valid_o      = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o     <= head_i.burst ? store_q[rd_addr] : 8'd0;
      byte_valid_o   <= head_i.burst;
      last_o         <= is_last;
      status_o       <= head_i.status;
      count_o        <= head_i.count;
      read_counter_o <= head_i.rd_cnt;
      fill_level_o   <= brbo_pkg::FILL_W'(fill);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (slot_free) begin
        out_valid_q <= !q_empty_i;
      end
      if (load) begin
        idx_q <= is_last ? '0 : idx_q + brbo_pkg::BURST_W'(1);
      end
    end
  end

endmodule

// File: sv/byte_ring_buffer_overwrite_peek_unit.sv
// Top level of the byte ring buffer with overwrite and peek.
// Connects brbo_front, brbo_cmd_q and brbo_back; uses brbo_pkg.
//
// Usage: command words enter on the s_axis channel, result words leave on the
// m_axis channel, and the two ring settings are written on the cfg channel,
// which is always ready and must be used only while the block is idle.
// Every command gives one result word, except a read or peek that returns
// bytes, which gives one word per byte, up to 64, with tlast on the final one.
// A command accepted into the queue is loaded into the output register once it
// is at the head and the register is free. The front end takes one command
// per cycle while the queue has room and no write waits on a queued burst;
// a burst gives its bytes one per cycle while the receiver takes them, from the
// single read port of the byte store. A write waits while a read or
// peek burst is still queued, so the store is never changed under it.
// Reset clears both counters and the chunk state and restores a 1024-byte
// ring without overwrite; the store itself is not cleared.
// When the receiver stalls, the output register holds its word, the queue
// fills, and then s_axis_tready drops until words are taken again.
module byte_ring_buffer_overwrite_peek_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], chunk_length[23:8], request_count[39:24], snapshot_value[71:40]
  input  logic [71:0] s_axis_tdata,
  // opcode[2:0], first_of_chunk[3]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], count[23:8], read_counter[55:24], fill_level[66:56], zeros[71:67]
  output logic [71:0] m_axis_tdata,
  // byte_valid[0], status[2:1]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  brbo_pkg::front_stat_t       fstat;
  brbo_pkg::back_ctl_t         bctl;
  brbo_pkg::cmd_t              cmd;
  brbo_pkg::cmd_t              head;
  brbo_pkg::mem_wr_t           wr;
  logic                        push;
  logic                        q_full;
  logic                        q_empty;
  logic [7:0]                  out_byte;
  logic                        byte_valid;
  brbo_pkg::status_e           status;
  logic [15:0]                 count;
  logic [31:0]                 read_counter;
  logic [brbo_pkg::FILL_W-1:0] fill_level;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = fstat.in_ready;

  brbo_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid),
    .opcode_i         (s_axis_tuser[2:0]),
    .data_byte_i      (s_axis_tdata[7:0]),
    .first_of_chunk_i (s_axis_tuser[3]),
    .chunk_length_i   (s_axis_tdata[23:8]),
    .request_count_i  (s_axis_tdata[39:24]),
    .snapshot_value_i (s_axis_tdata[71:40]),
    .q_full_i         (q_full),
    .back_i           (bctl),
    .stat_o           (fstat),
    .push_o           (push),
    .cmd_o            (cmd),
    .wr_o             (wr)
  );

  brbo_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (bctl.pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  brbo_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .head_i         (head),
    .q_empty_i      (q_empty),
    .ctl_o          (bctl),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_byte_o     (out_byte),
    .byte_valid_o   (byte_valid),
    .last_o         (m_axis_tlast),
    .status_o       (status),
    .count_o        (count),
    .read_counter_o (read_counter),
    .fill_level_o   (fill_level)
  );

  assign m_axis_tdata = {5'd0, fill_level, read_counter, count, out_byte};
  assign m_axis_tuser = {status, byte_valid};

`ifndef NO_ASSERTIONS
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bctl.pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_no_store_under_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (fstat.pend_cnt == '0))
    else $error("byte store written while a burst is pending");

  a_fill_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(fill_level) <= 32'(brbo_pkg::MAX_FILL)))
    else $error("fill level above ring capacity");
`endif

endmodule
